>>> rtl/mfc_pkg.sv
// Shared types, constants and helpers for the magnetometer frame calibrator.
package mfc_pkg;

    localparam int Sensors     = 9;
    localparam int CalFrames   = 20;
    localparam int BufferLimit = 512;
    localparam int NumVal      = Sensors * 3;
    localparam int PayloadLen  = Sensors * 12;
    localparam int NumCoef     = Sensors * 9;
    localparam logic [31:0] Trailer = 32'hDEADBEEF;

    localparam int ValW = $clog2(NumVal);
    localparam int PayW = $clog2(PayloadLen);
    localparam int CoefW = $clog2(NumCoef);

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [6:0]  coef_index;
        logic signed [15:0] coef_value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  sensor_index;
        logic [1:0]  axis;
        logic signed [31:0] field_value;
        logic        last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV_RD,
        ST_CONV_ACC,
        ST_DIV,
        ST_ROT_RD,
        ST_ROT_MAC,
        ST_ROT_OUT,
        ST_EMIT
    } state_t;

    // Float bits to signed Q23.8: truncate, saturate, NaN and subnormals to zero.
    function automatic logic signed [31:0] float_to_q8(input logic [31:0] bits);
        logic [7:0]  e;
        logic [23:0] m;
        logic [31:0] mag;
        logic        neg;
        logic [4:0]  sh;
        logic signed [31:0] r;
        e   = bits[30:23];
        neg = bits[31];
        m   = {1'b1, bits[22:0]};
        mag = '0;
        sh  = '0;
        r   = '0;
        if (e == 8'hFF) begin
            if (bits[22:0] != '0) r = '0;
            else r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (e == 8'h00) begin
            r = '0;
        end else if (e >= 8'd150) begin
            r = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (e >= 8'd142) begin
            sh  = 5'(e - 8'd142);
            mag = {8'd0, m} << sh;
            r   = neg ? -$signed(mag) : $signed(mag);
        end else if (e <= 8'd117) begin
            r = '0;
        end else begin
            sh  = 5'(8'd142 - e);
            mag = {8'd0, m >> sh};
            r   = neg ? -$signed(mag) : $signed(mag);
        end
        return r;
    endfunction

endpackage

>>> rtl/mfc_mac.sv
// Shared multiply-accumulate unit: one 33x16 product per cycle into a wide accumulator.
module mfc_mac
    import mfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               en,
    input  logic signed [32:0] a,
    input  logic signed [15:0] b,
    output logic signed [51:0] acc
);
    logic signed [48:0] prod_reg, prod_next;
    logic               pv_reg, pv_next;
    logic signed [51:0] acc_reg, acc_next;

    always_comb
    begin
        prod_next = a * b;
        pv_next   = en;
        acc_next  = acc_reg;
        if (clear)
            acc_next = '0;
        else if (pv_reg)
            acc_next = acc_reg + 52'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            acc_reg <= '0;
        end
        else
        begin
            pv_reg  <= pv_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign acc = acc_reg;
endmodule

>>> rtl/magnetometer_frame_calibrator.sv
// Top level of the magnetometer frame calibrator.
// Serial bytes and Q1.14 direction coefficient writes arrive as input words. When
// a valid 112-byte frame ends on the trailer DE AD BE EF the block runs its frame
// sequencer, not ready meanwhile: 27 float conversions (each four byte reads and
// one accumulate); during calibration, after the last calibration frame, 27
// divisions by 20 (reciprocal by shifted sums, one remainder correction, write
// back and load); afterwards 27 values through the single shared multiplier, each
// result held until taken, so a slow receiver stretches the frame. Memories:
// payload bytes, converted values, baselines, coefficients. No clearing pass.
module magnetometer_frame_calibrator
    import mfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);
    state_t state_reg, state_next;

    logic [9:0]  count_reg, count_next;
    logic [31:0] recent_reg, recent_next;
    logic [4:0]  calf_reg, calf_next;
    logic        cal_reg, cal_next;

    logic [7:0]  pay_mem [PayloadLen];
    logic [31:0] word_reg;
    logic signed [32:0] val_mem [NumVal];
    logic signed [15:0] coef_mem [NumCoef];
    logic [NumCoef-1:0] coef_vld_reg;
    logic signed [15:0] coef_q_reg;
    logic               coef_qv_reg;
    logic signed [37:0] base_mem [NumVal];
    logic [NumVal-1:0] base_vld_reg;

    logic [ValW-1:0] idx_reg, idx_next;
    logic [1:0]  byt_reg, byt_next;
    logic [1:0]  k_reg, k_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  sens_reg, sens_next;
    logic [1:0]  oax_reg, oax_next;

    // divider working registers
    logic [37:0] dq_reg, dq_next;
    logic [37:0] qe_reg, qe_next;
    logic [5:0]  dr_reg, dr_next;
    logic        dneg_reg, dneg_next;

    logic signed [32:0] mac_a;
    logic signed [15:0] mac_b;
    logic               mac_en, mac_clr;
    logic signed [51:0] mac_acc;
    out_word_t out_reg, out_next;
    logic      ov_reg, ov_next;

    logic in_fire, byte_fire, frame_go;
    logic [9:0] cnt_wrap, cnt_inc;
    logic [31:0] rec_shift;
    logic signed [37:0] base_rd;
    logic [6:0] ci;
    logic [CoefW-1:0] coef_addr;
    logic signed [15:0] coef_rd;
    logic signed [51:0] mag;
    logic signed [51:0] shr;

    mfc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (mac_clr),
        .en    (mac_en),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign byte_fire = in_fire && !in_data.req_type;
    assign cnt_wrap  = (count_reg + 10'd1 > 10'(BufferLimit)) ? 10'd0 : count_reg;
    assign cnt_inc   = cnt_wrap + 10'd1;
    assign rec_shift = {recent_reg[23:0], in_data.data_byte};
    assign frame_go  = byte_fire && (rec_shift == Trailer) && (cnt_inc == 10'(PayloadLen + 4));

    assign base_rd   = base_vld_reg[idx_reg] ? base_mem[idx_reg] : '0;
    // coefficient for the next tap is registered in the cycle before its use
    assign ci        = 7'(((sens_reg * 3) + oax_reg) * 3 + k_next);
    assign coef_addr = CoefW'(ci);
    assign coef_rd   = coef_qv_reg ? coef_q_reg : '0;
    assign mac_a     = val_mem[ValW'(sens_reg * 3 + k_reg)];
    assign mac_b     = coef_rd;
    assign mag       = mac_acc < 0 ? -mac_acc : mac_acc;
    assign shr       = mac_acc < 0 ? -(mag >>> 14) : (mag >>> 14);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (frame_go) state_next = ST_CONV_RD;
            ST_CONV_RD:  if (byt_reg == 2'd3) state_next = ST_CONV_ACC;
            ST_CONV_ACC:
                if (idx_reg == ValW'(NumVal - 1))
                begin
                    if (!cal_reg)
                        state_next = (calf_reg + 5'd1 >= 5'(CalFrames)) ? ST_DIV : ST_IDLE;
                    else
                        state_next = ST_ROT_RD;
                end
                else
                    state_next = ST_CONV_RD;
            ST_DIV:
                if (cnt_reg == 6'd9 && idx_reg == ValW'(NumVal - 1)) state_next = ST_IDLE;
            ST_ROT_RD:   state_next = ST_ROT_MAC;
            ST_ROT_MAC:  if (k_reg == 2'd2) state_next = ST_ROT_OUT;
            ST_ROT_OUT:  if (cnt_reg == 6'd1) state_next = ST_EMIT;
            ST_EMIT:
                if (!ov_reg || out_ready)
                    state_next = (sens_reg == 4'(Sensors - 1) && oax_reg == 2'd2) ?
                                 ST_IDLE : ST_ROT_RD;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        recent_next = recent_reg;
        calf_next = calf_reg;
        cal_next  = cal_reg;
        idx_next  = idx_reg;
        byt_next  = byt_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        sens_next = sens_reg;
        oax_next  = oax_reg;
        dq_next   = dq_reg;
        qe_next   = qe_reg;
        dr_next   = dr_reg;
        dneg_next = dneg_reg;
        mac_en    = 1'b0;
        mac_clr   = 1'b0;
        out_next  = out_reg;
        ov_next   = ov_reg;
        if (ov_reg && out_ready) ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_fire)
                begin
                    recent_next = rec_shift;
                    count_next = ((cnt_inc >= 10'd4) && (rec_shift == Trailer)) ? 10'd0 : cnt_inc;
                end
                idx_next = '0;
                byt_next = '0;
            end
            ST_CONV_RD:  byt_next = byt_reg + 2'd1;
            ST_CONV_ACC:
            begin
                byt_next = '0;
                idx_next = idx_reg + ValW'(1);
                if (idx_reg == ValW'(NumVal - 1))
                begin
                    idx_next = '0;
                    cnt_next = '0;
                    sens_next = '0;
                    oax_next = '0;
                    k_next = '0;
                    if (!cal_reg)
                    begin
                        calf_next = calf_reg + 5'd1;
                        if (calf_reg + 5'd1 >= 5'(CalFrames))
                        begin
                            dq_next = base_mem[0] < 0 ? 38'(-base_mem[0]) : 38'(base_mem[0]);
                            dneg_next = base_mem[0] < 0;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                // x/20: estimate 0.8x/16 by shifted sums (low by at most one), then
                // correct once from the remainder, then write back and load the next operand
                unique case (cnt_reg)
                    6'd0:    qe_next = (dq_reg >> 1) + (dq_reg >> 2);
                    6'd1:    qe_next = qe_reg + (qe_reg >> 4);
                    6'd2:    qe_next = qe_reg + (qe_reg >> 8);
                    6'd3:    qe_next = qe_reg + (qe_reg >> 16);
                    6'd4:    qe_next = qe_reg + (qe_reg >> 32);
                    6'd5:    qe_next = qe_reg >> 4;
                    6'd6:    dr_next = dq_reg[5:0] - {qe_reg[1:0], 4'd0} - {qe_reg[3:0], 2'd0};
                    6'd7:    qe_next = qe_reg + 38'(dr_reg >= 6'd20);
                    default: ;
                endcase
                if (cnt_reg == 6'd9)
                begin
                    cnt_next = '0;
                    idx_next = idx_reg + ValW'(1);
                    if (idx_reg == ValW'(NumVal - 1))
                    begin
                        cal_next = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        dq_next = base_mem[idx_reg + ValW'(1)] < 0 ?
                                  38'(-base_mem[idx_reg + ValW'(1)]) :
                                  38'(base_mem[idx_reg + ValW'(1)]);
                        dneg_next = base_mem[idx_reg + ValW'(1)] < 0;
                    end
                end
                else
                    cnt_next = cnt_reg + 6'd1;
            end
            ST_ROT_RD:
            begin
                mac_clr = 1'b1;
                k_next = '0;
                cnt_next = '0;
            end
            ST_ROT_MAC:
            begin
                mac_en = 1'b1;
                k_next = k_reg + 2'd1;
            end
            ST_ROT_OUT:
                cnt_next = cnt_reg + 6'd1;
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    out_next.sensor_index = sens_reg;
                    out_next.axis = oax_reg;
                    out_next.field_value = (shr > 52'sd2147483647) ? 32'sh7FFF_FFFF :
                        (shr < -52'sd2147483648) ? 32'sh8000_0000 : 32'(shr);
                    out_next.last = (sens_reg == 4'(Sensors - 1)) && (oax_reg == 2'd2);
                    if (oax_reg == 2'd2)
                    begin
                        oax_next = '0;
                        sens_next = sens_reg + 4'd1;
                    end
                    else
                        oax_next = oax_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // memories and payload registers
    always_ff @(posedge clk)
    begin
        if (byte_fire && cnt_wrap < 10'(PayloadLen))
            pay_mem[PayW'(cnt_wrap)] <= in_data.data_byte;
        if (state_reg == ST_CONV_RD)
            word_reg <= {pay_mem[PayW'({idx_reg, byt_reg})], word_reg[31:8]};
        if (state_reg == ST_CONV_ACC)
        begin
            if (cal_reg)
                val_mem[idx_reg] <= 33'(float_to_q8(word_reg)) - 33'(base_rd);
            base_mem[idx_reg] <= cal_reg ? base_mem[idx_reg]
                                         : base_rd + 38'(float_to_q8(word_reg));
        end
        if (in_fire && in_data.req_type && in_data.coef_index < 7'(NumCoef))
            coef_mem[CoefW'(in_data.coef_index)] <= in_data.coef_value;
        if (state_reg == ST_ROT_RD || (state_reg == ST_ROT_MAC && k_reg != 2'd2))
        begin
            coef_q_reg  <= coef_mem[coef_addr];
            coef_qv_reg <= coef_vld_reg[coef_addr];
        end
        if (state_reg == ST_DIV && cnt_reg == 6'd8)
            base_mem[idx_reg] <= dneg_reg ? -$signed(qe_reg) : $signed(qe_reg);
        dq_reg   <= dq_next;
        qe_reg   <= qe_next;
        dneg_reg <= dneg_next;
        dr_reg   <= dr_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            recent_reg <= '0;
            calf_reg <= '0;
            cal_reg <= 1'b0;
            idx_reg <= '0;
            byt_reg <= '0;
            k_reg <= '0;
            cnt_reg <= '0;
            sens_reg <= '0;
            oax_reg <= '0;
            ov_reg <= 1'b0;
            coef_vld_reg <= '0;
            base_vld_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            recent_reg <= recent_next;
            calf_reg <= calf_next;
            cal_reg <= cal_next;
            idx_reg <= idx_next;
            byt_reg <= byt_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            sens_reg <= sens_next;
            oax_reg <= oax_next;
            ov_reg <= ov_next;
            if (in_fire && in_data.req_type && in_data.coef_index < 7'(NumCoef))
                coef_vld_reg[CoefW'(in_data.coef_index)] <= 1'b1;
            if (state_reg == ST_CONV_ACC && !cal_reg)
                base_vld_reg[idx_reg] <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 10'(BufferLimit)) else $error("byte count overflow");
    a_cal_frames: assert property (@(posedge clk) disable iff (!rst_n)
        cal_reg |-> calf_reg == 5'(CalFrames)) else $error("calibrated early");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
`endif
endmodule

>>> bench/magnetometer_frame_calibrator_test.sv
// Self-checking bench for the magnetometer frame calibrator: framing, calibration, rotation.
module magnetometer_frame_calibrator_test;
    import mfc_pkg::*;

    localparam int SettleCycles = 1500;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    magnetometer_frame_calibrator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predicted state of the block
    int                 pred_count;
    logic [31:0]        pred_recent;
    logic [7:0]         pred_payload [PayloadLen];
    int                 pred_cal_frames;
    bit                 pred_calibrated;
    longint             pred_baseline [NumVal];
    logic signed [15:0] pred_coef [NumCoef];

    out_word_t expected_fields [$];
    int        errors;
    int        words_sent;
    int        burst_left;
    bit        rx_hold_req;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint float_bits_to_q8(logic [31:0] f);
        int     ex;
        int     sh;
        longint mag;
        ex = f[30:23];
        mag = {40'd0, 1'b1, f[22:0]};
        if (ex == 255)
        begin
            if (f[22:0] != 0) return 0;
            return f[31] ? -64'sd2147483648 : 64'sd2147483647;
        end
        if (ex == 0) return 0;
        sh = ex - 142;
        if (sh >= 8) return f[31] ? -64'sd2147483648 : 64'sd2147483647;
        if (sh >= 0) mag = mag << sh;
        else if (sh <= -25) mag = 0;
        else mag = mag >> (-sh);
        return clamp32(f[31] ? -mag : mag);
    endfunction

    task automatic close_frame();
        longint    vals [NumVal];
        longint    acc;
        out_word_t r;
        for (int i = 0; i < NumVal; i++)
            vals[i] = float_bits_to_q8({pred_payload[4*i+3], pred_payload[4*i+2],
                                        pred_payload[4*i+1], pred_payload[4*i]});
        if (!pred_calibrated)
        begin
            for (int i = 0; i < NumVal; i++) pred_baseline[i] += vals[i];
            pred_cal_frames++;
            if (pred_cal_frames >= CalFrames)
            begin
                for (int i = 0; i < NumVal; i++) pred_baseline[i] = pred_baseline[i] / CalFrames;
                pred_calibrated = 1'b1;
            end
            return;
        end
        for (int i = 0; i < NumVal; i++) vals[i] -= pred_baseline[i];
        for (int s = 0; s < Sensors; s++)
            for (int o = 0; o < 3; o++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += vals[s*3+k] * longint'(pred_coef[(s*3+o)*3+k]);
                // shift toward zero
                acc = (acc < 0) ? -((-acc) >> 14) : (acc >> 14);
                r.sensor_index = 4'(s);
                r.axis         = 2'(o);
                r.field_value  = 32'(clamp32(acc));
                r.last         = (s == Sensors - 1) && (o == 2);
                expected_fields.push_back(r);
            end
    endtask

    task automatic track_word(in_word_t w);
        if (w.req_type)
        begin
            if (w.coef_index < NumCoef) pred_coef[w.coef_index] = w.coef_value;
            return;
        end
        if (pred_count + 1 > BufferLimit) pred_count = 0;
        if (pred_count < PayloadLen) pred_payload[pred_count] = w.data_byte;
        pred_count++;
        pred_recent = {pred_recent[23:0], w.data_byte};
        if (pred_count >= 4 && pred_recent == Trailer)
        begin
            if (pred_count == PayloadLen + 4) close_frame();
            pred_count = 0;
        end
    endtask

    task automatic send_word(in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        track_word(w);
        words_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        in_word_t w;
        w.req_type   = 1'b0;
        w.data_byte  = b;
        w.coef_index = 7'($urandom);
        w.coef_value = 16'($urandom);
        send_word(w);
    endtask

    task automatic send_coef(int idx, int val);
        in_word_t w;
        w.req_type   = 1'b1;
        w.data_byte  = 8'($urandom);
        w.coef_index = 7'(idx);
        w.coef_value = 16'(val);
        send_word(w);
    endtask

    task automatic send_trailer();
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_byte(8'hBE);
        send_byte(8'hEF);
    endtask

    function automatic logic [31:0] pick_float();
        int          cls;
        logic [7:0]  ex;
        logic [31:0] mant;
        cls  = $urandom_range(0, 19);
        mant = $urandom;
        case (cls)
            0: ex = 8'hFF;
            1: ex = 8'h00;
            2: ex = 8'($urandom_range(142, 254));
            3: ex = 8'($urandom_range(100, 125));
            default: ex = 8'($urandom_range(126, 141));
        endcase
        if (cls == 0 && $urandom_range(0, 1)) mant = 0;
        return {1'($urandom), ex, mant[22:0]};
    endfunction

    // payload of Sensors*3 floats then trailer; extra bytes make it the wrong length
    task automatic send_frame(int extra);
        logic [31:0] f;
        for (int i = 0; i < NumVal; i++)
        begin
            f = pick_float();
            for (int b = 0; b < 4; b++) send_byte(f[8*b +: 8]);
        end
        repeat (extra) send_byte(8'($urandom_range(0, 127)));
        send_trailer();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // receiver: random stall patterns, with an occasional long hold
    initial
    begin
        int mode;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            for (int c = 0; c < 50; c++)
            begin
                @(negedge clk);
                if (rx_hold_req)
                begin
                    rx_hold_req = 1'b0;
                    out_ready <= 1'b0;
                    repeat (800) @(negedge clk);
                end
                case (mode)
                    0, 1: out_ready <= 1'b1;
                    2: out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_fields.size() == 0)
            begin
                $display("%0t: unexpected word, actual %p", $time, out_data);
                errors++;
            end
            else
            begin
                e = expected_fields.pop_front();
                if (out_data.sensor_index !== e.sensor_index)
                begin
                    $display("%0t: sensor_index expected %0d actual %0d", $time,
                             e.sensor_index, out_data.sensor_index);
                    errors++;
                end
                if (out_data.axis !== e.axis)
                begin
                    $display("%0t: axis expected %0d actual %0d", $time,
                             e.axis, out_data.axis);
                    errors++;
                end
                if (out_data.field_value !== e.field_value)
                begin
                    $display("%0t: field_value expected %0d actual %0d", $time,
                             e.field_value, out_data.field_value);
                    errors++;
                end
                if (out_data.last !== e.last)
                begin
                    $display("%0t: last expected %0d actual %0d", $time,
                             e.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_coef(0, 32767);
        send_coef(NumCoef - 1, -32768);
        send_coef(NumCoef, 1234);          // out of range, ignored
        send_coef(127, -1);                // ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        send_trailer();                    // wrong length, dropped
        send_trailer();                    // straight after a restart, count of four
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_trailer();
    endtask

    task automatic test_calibration();
        for (int n = 0; n < CalFrames; n++)
        begin
            if (n == 5) send_frame(1);     // too long, does not count
            if (n % 4 == 0) send_coef($urandom_range(0, 127), $urandom);
            send_frame(0);
        end
        wait_drained();
    endtask

    task automatic load_matrix();
        for (int i = 0; i < NumCoef; i++)
            send_coef(i, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32767) - 16384);
    endtask

    task automatic test_rotation();
        load_matrix();
        send_frame(0);
        rx_hold_req = 1'b1;                // results back up, input stalls
        send_frame(0);
        send_frame(0);
        wait_drained();
        // full-scale coefficients to push the sums into saturation
        for (int i = 0; i < NumCoef; i++) send_coef(i, (i % 2) ? -32768 : 32767);
        send_frame(0);
        send_frame(0);
        wait_drained();
    endtask

    task automatic test_buffer_wrap();
        // count is zero here; fill to the limit without a trailer
        repeat (BufferLimit - 3) send_byte(8'($urandom_range(0, 127)));
        send_byte(8'hDE);
        send_byte(8'hAD);
        send_byte(8'hBE);
        send_byte(8'hEF);                  // lands after the wrap: count below four
        send_frame(0);                     // off by one, dropped
        send_frame(0);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int start;
        int pick;
        start = words_sent;
        load_matrix();
        while (words_sent - start < 480)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6) send_frame(0);
            else if (pick == 6) send_frame($urandom_range(1, 8) * (1 - 2 * 0) - 0);
            else if (pick == 7)
                repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
            else if (pick == 8)
                repeat ($urandom_range(1, 6)) send_coef($urandom_range(0, 127), $urandom);
            else
            begin
                repeat ($urandom_range(0, 100)) send_byte(8'($urandom_range(0, 127)));
                send_trailer();            // short frame, dropped
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        errors      = 0;
        words_sent  = 0;
        burst_left  = 0;
        rx_hold_req = 1'b0;
        pred_count  = 0;
        pred_recent = '0;
        pred_cal_frames = 0;
        pred_calibrated = 1'b0;
        for (int i = 0; i < NumVal; i++) pred_baseline[i] = 0;
        for (int i = 0; i < NumCoef; i++) pred_coef[i] = '0;
        for (int i = 0; i < PayloadLen; i++) pred_payload[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_calibration();
        test_rotation();
        test_buffer_wrap();
        test_random_mix();
        wait_drained();

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/mfc_pkg.sv
rtl/mfc_mac.sv
rtl/magnetometer_frame_calibrator.sv
bench/magnetometer_frame_calibrator_test.sv
